// ===== rtl/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and codes for the multi-queue shared buffer: request
// operation codes, result status codes, sequencer states and the control
// structs passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

   // request operation codes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENQ,
      ST_DQ_HEAD,
      ST_DQ_DONE
   } state_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic head_null;   // addressed queue has no head slot
      logic out_free;    // result register can take a beat this cycle
   } sts_type;

   // strobes from the sequencer to the datapath
   typedef struct packed {
      logic accept;      // request beat taken, table reads issued
      logic enq_commit;  // enqueue finishes, pointer updates written
      logic dq_issue;    // read link and value of the head slot
      logic dq_commit;   // dequeue finishes, slot returned to free chain
      logic empty_done;  // dequeue of an empty queue finishes
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/mqsb_ram.sv =====
// ----------------------------------------------------------------------------
// mqsb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. A read and a write to the same address in one
// cycle return the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mqsb_fsm.sv =====
// ----------------------------------------------------------------------------
// mqsb_fsm
// Request sequencer: takes one request at a time, walks it through the
// table read, the optional head-slot read and the commit cycle, and waits
// in the commit state while the result register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_fsm (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_operation,
   input  wire mqsb_pkg::sts_type sts,
   output      logic              req_ready,
   output      mqsb_pkg::ctl_type ctl
);

   mqsb_pkg::state_type state_ff;
   mqsb_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqsb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqsb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == mqsb_pkg::OP_DEQ) ?
                          mqsb_pkg::ST_DQ_HEAD : mqsb_pkg::ST_ENQ;
            end
         end
         mqsb_pkg::ST_ENQ: begin
            if (sts.out_free) state_in = mqsb_pkg::ST_IDLE;
         end
         mqsb_pkg::ST_DQ_HEAD: begin
            if (!sts.head_null) begin
               state_in = mqsb_pkg::ST_DQ_DONE;
            end else if (sts.out_free) begin
               state_in = mqsb_pkg::ST_IDLE;
            end
         end
         mqsb_pkg::ST_DQ_DONE: begin
            if (sts.out_free) state_in = mqsb_pkg::ST_IDLE;
         end
         default: state_in = mqsb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         mqsb_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
         end
         mqsb_pkg::ST_ENQ: begin
            ctl.enq_commit = sts.out_free;
         end
         mqsb_pkg::ST_DQ_HEAD: begin
            ctl.dq_issue   = !sts.head_null;
            ctl.empty_done = sts.head_null && sts.out_free;
         end
         mqsb_pkg::ST_DQ_DONE: begin
            ctl.dq_commit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues sharing one slot store, chained through a link RAM,
// with a free chain of unused slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per request, req_operation selects enqueue or
//   dequeue, req_queue_id the queue (taken modulo NUM_QUEUES), req_data_in
//   the value to enqueue. rsp_ channel: exactly one beat per request with
//   rsp_data_out and rsp_status (ok, store full, queue empty).
//   Sequence: enqueue and empty dequeue load their result after the queue
//   table read, a dequeue that finds data after the head-slot read as well.
//   One request is worked on at a time; the next request is taken once the
//   sequencer is back in idle after the result is loaded. The pace is set
//   by the registered reads of the queue table and of the link RAM,
//   which a dequeue needs back to back (queue head, then its link).
//   A finished result sits in an output register; the next request is
//   accepted while it waits. A request that finishes while that register
//   is still full waits in its commit state until rsp_ready frees it.
//   Reset: all queues empty, free chain 0, 1, ... , last. The queue table
//   has a valid bit per queue and slots never handed out are tracked by a
//   fill count, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer #(
   parameter int NUM_ENTRIES = 256,
   parameter int NUM_QUEUES  = 8,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_operation,
   input  wire logic [2:0]         req_queue_id,
   input  wire logic signed [31:0] req_data_in,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [31:0] rsp_data_out,
   output      logic [1:0]         rsp_status
);

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int PW = $clog2(NUM_ENTRIES + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [PW-1:0] PTR_NULL = PW'(NUM_ENTRIES);

   mqsb_pkg::ctl_type ctl;
   mqsb_pkg::sts_type sts;

   logic [PW-1:0]         free_head_ff, free_head_in;
   logic [PW-1:0]         fill_ff, fill_in;
   logic [QW-1:0]         q_ff;
   logic [NUM_QUEUES-1:0] qv_ff, qv_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_data_out_ff, rsp_data_out_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic [8:0]          qrem;
   logic [QW-1:0]       q_sel;
   logic                out_free;
   logic                load;

   logic                link_we, link_re;
   logic [AW-1:0]       link_waddr, link_raddr;
   logic [PW-1:0]       link_wdata, link_rd;
   logic                qtab_we;
   logic [2*PW-1:0]     qtab_wdata, qtab_rd;
   logic                val_we;
   logic [DATA_WIDTH-1:0] val_rd;

   logic [PW-1:0]       head_rd, tail_rd, new_head;
   logic                slot_ok, head_ok, tail_ok, slot_fresh;
   logic [63:0]         val64;
   logic [31:0]         val_ext;

   // queue number modulo the queue count, by repeated subtraction
   always_comb begin
      qrem = {6'd0, req_queue_id};
      for (int i = 0; i < 8; i++) begin
         if (qrem >= 9'(NUM_QUEUES)) qrem = qrem - 9'(NUM_QUEUES);
      end
      q_sel = QW'(qrem);
   end

   // sequencer
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign sts.out_free  = out_free;
   assign sts.head_null = !head_ok;

   mqsb_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .sts           (sts),
      .req_ready     (req_ready),
      .ctl           (ctl)
   );

   // queue table entry, invalid entries read as an empty queue
   assign head_rd = qv_ff[q_ff] ? qtab_rd[2*PW-1:PW] : PTR_NULL;
   assign tail_rd = qv_ff[q_ff] ? qtab_rd[PW-1:0]    : PTR_NULL;

   assign slot_ok    = free_head_ff < PTR_NULL;
   assign head_ok    = head_rd < PTR_NULL;
   assign tail_ok    = tail_rd < PTR_NULL;
   assign slot_fresh = free_head_ff >= fill_ff;
   assign new_head   = head_ok ? head_rd : free_head_ff;

   // link RAM port control
   always_comb begin
      link_we    = 1'b0;
      link_waddr = free_head_ff[AW-1:0];
      link_wdata = PTR_NULL;
      if (ctl.accept && req_operation == mqsb_pkg::OP_ENQ && slot_ok) begin
         // the slot being taken ends its new chain
         link_we = 1'b1;
      end else if (ctl.enq_commit && slot_ok && head_ok && tail_ok) begin
         link_we    = 1'b1;
         link_waddr = tail_rd[AW-1:0];
         link_wdata = free_head_ff;
      end else if (ctl.dq_commit) begin
         link_we    = 1'b1;
         link_waddr = head_rd[AW-1:0];
         link_wdata = free_head_ff;
      end
   end

   assign link_re    = (ctl.accept && req_operation == mqsb_pkg::OP_ENQ) || ctl.dq_issue;
   assign link_raddr = ctl.dq_issue ? head_rd[AW-1:0] : free_head_ff[AW-1:0];

   mqsb_ram #(
      .WIDTH (PW),
      .DEPTH (NUM_ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   // queue table: head and tail pointer per queue
   assign qtab_we    = (ctl.enq_commit && slot_ok) || ctl.dq_commit;
   assign qtab_wdata = ctl.dq_commit ? {link_rd, tail_rd} : {new_head, free_head_ff};

   mqsb_ram #(
      .WIDTH (2 * PW),
      .DEPTH (NUM_QUEUES)
   ) u_qtab_ram (
      .clock   (clock),
      .wr_en   (qtab_we),
      .wr_addr (q_ff),
      .wr_data (qtab_wdata),
      .rd_en   (ctl.accept),
      .rd_addr (q_sel),
      .rd_data (qtab_rd)
   );

   // value store, written as soon as the slot is known
   assign val_we = ctl.accept && req_operation == mqsb_pkg::OP_ENQ && slot_ok;

   mqsb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (free_head_ff[AW-1:0]),
      .wr_data (DATA_WIDTH'(req_data_in)),
      .rd_en   (ctl.dq_issue),
      .rd_addr (head_rd[AW-1:0]),
      .rd_data (val_rd)
   );

   // sign extension of the stored value to the result width
   always_comb begin
      val64 = 64'(val_rd);
      for (int i = 0; i < 32; i++) begin
         val_ext[i] = (i < DATA_WIDTH) ? val64[i] : val64[DATA_WIDTH-1];
      end
   end

   // free chain, fill count, queue valid bits
   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      qv_in        = qv_ff;
      if (ctl.enq_commit && slot_ok) begin
         // slots at or past the fill count were never handed out, so the next one follows
         free_head_in = slot_fresh ? free_head_ff + 1'b1 : link_rd;
         if (slot_fresh) fill_in = fill_ff + 1'b1;
      end else if (ctl.dq_commit) begin
         free_head_in = head_rd;
      end
      if (qtab_we) qv_in[q_ff] = 1'b1;
   end

   // result register
   assign load = ctl.enq_commit || ctl.empty_done || ctl.dq_commit;

   always_comb begin
      rsp_valid_in    = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_out_in = rsp_data_out_ff;
      rsp_status_in   = rsp_status_ff;
      if (ctl.enq_commit) begin
         rsp_data_out_in = '0;
         rsp_status_in   = slot_ok ? mqsb_pkg::STATUS_OK : mqsb_pkg::STATUS_FULL;
      end else if (ctl.empty_done) begin
         rsp_data_out_in = '1;
         rsp_status_in   = mqsb_pkg::STATUS_EMPTY;
      end else if (ctl.dq_commit) begin
         rsp_data_out_in = val_ext;
         rsp_status_in   = mqsb_pkg::STATUS_OK;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fill_ff      <= '0;
         qv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         qv_ff        <= qv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) q_ff <= q_sel;
      rsp_data_out_ff <= rsp_data_out_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_out_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= PTR_NULL)
      else $error("free head pointer out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PTR_NULL)
      else $error("fill count out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> !req_ready)
      else $error("request taken while another is in progress");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded over a pending beat");

   a_slot_taken: assert property (@(posedge clock) disable iff (reset)
      ctl.enq_commit && slot_ok |=> free_head_ff != $past(free_head_ff))
      else $error("enqueue did not advance the free chain");

endmodule

`default_nettype wire

// ===== sim/mqsb_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqsb_checker
// Watches the request and result channels of the multi-queue shared buffer.
// Every accepted request beat runs through a behavioral copy of the queues,
// the link chain and the free chain. Every result beat is compared with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------

module mqsb_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_operation,
   input  wire logic [2:0]         req_queue_id,
   input  wire logic signed [31:0] req_data_in,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_data_out,
   input  wire logic [1:0]         rsp_status,
   output int                      fail_count,
   output int                      pending
);

   localparam int SLOTS     = 256;
   localparam int QUEUES    = 8;
   localparam int EXP_DEPTH = 16;
   localparam logic [8:0] NULL_SLOT = 9'd256;

   typedef logic [8:0] slot_type;

   typedef struct {
      logic               op;
      logic [2:0]         qid;
      logic signed [31:0] data;
      logic [1:0]         status;
   } outcome_type;

   // model of the queue table, link chain, slot values and free chain
   slot_type           head_slot [QUEUES];
   slot_type           tail_slot [QUEUES];
   slot_type           next_slot [SLOTS];
   logic signed [31:0] slot_value [SLOTS];
   slot_type           free_slot;

   // outstanding predictions, oldest at the read index
   outcome_type expected_outcomes [EXP_DEPTH];
   logic [3:0]  exp_rd_idx;
   logic [3:0]  exp_wr_idx;
   int          exp_count;
   int          errors = 0;

   // apply one request to the model and return the result it must give
   function automatic outcome_type serve_request(logic op, logic [2:0] qid,
                                                 logic signed [31:0] din);
      outcome_type r;
      slot_type    s;
      int          q;
      q        = int'(qid) % QUEUES;
      r.op     = op;
      r.qid    = qid;
      r.data   = 32'sd0;
      r.status = mqsb_pkg::STATUS_OK;
      if (op == mqsb_pkg::OP_ENQ) begin
         s = free_slot;
         if (s >= SLOTS) begin
            r.status = mqsb_pkg::STATUS_FULL;
         end else begin
            free_slot = next_slot[s];
            if (head_slot[q] >= SLOTS) begin
               head_slot[q] = s;
            end else if (tail_slot[q] < SLOTS) begin
               next_slot[tail_slot[q]] = s;
            end
            next_slot[s]  = NULL_SLOT;
            tail_slot[q]  = s;
            slot_value[s] = din;
         end
      end else begin
         s = head_slot[q];
         if (s >= SLOTS) begin
            r.status = mqsb_pkg::STATUS_EMPTY;
            r.data   = -32'sd1;
         end else begin
            // unlink the head slot and put it on the front of the free chain
            head_slot[q] = next_slot[s];
            next_slot[s] = free_slot;
            free_slot    = s;
            r.data       = slot_value[s];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type exp_beat;
      int          i;
      if (reset) begin
         // all queues empty, free chain runs through every slot in order
         for (i = 0; i < QUEUES; i++) begin
            head_slot[i] = NULL_SLOT;
            tail_slot[i] = NULL_SLOT;
         end
         for (i = 0; i < SLOTS; i++) begin
            next_slot[i]  = slot_type'(i + 1);
            slot_value[i] = 32'sd0;
         end
         next_slot[SLOTS-1] = NULL_SLOT;
         free_slot          = 9'd0;
         exp_rd_idx         = 4'd0;
         exp_wr_idx         = 4'd0;
         exp_count          = 0;
      end else begin
         // result beat: compare before this edge's request is predicted
         if (rsp_valid && rsp_ready) begin
            if (exp_count == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%t: result beat with nothing outstanding: data %0d status %0d",
                           $realtime, rsp_data_out, rsp_status);
            end else begin
               exp_beat   = expected_outcomes[exp_rd_idx];
               exp_rd_idx = exp_rd_idx + 4'd1;
               exp_count  = exp_count - 1;
               if (rsp_data_out !== exp_beat.data || rsp_status !== exp_beat.status) begin
                  errors++;
                  if (errors <= 10)
                     $display("%t: op %0d q %0d exp data %0d st %0d, got data %0d st %0d",
                              $realtime, exp_beat.op, exp_beat.qid, exp_beat.data,
                              exp_beat.status, rsp_data_out, rsp_status);
               end
            end
         end
         // request beat
         if (req_valid && req_ready) begin
            if (exp_count == EXP_DEPTH) begin
               errors++;
               if (errors <= 10)
                  $display("%t: too many request beats outstanding", $realtime);
            end else begin
               expected_outcomes[exp_wr_idx] = serve_request(req_operation,
                                                             req_queue_id,
                                                             req_data_in);
               exp_wr_idx = exp_wr_idx + 4'd1;
               exp_count  = exp_count + 1;
            end
         end
      end
      fail_count <= errors;
      pending    <= exp_count;
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the multi-queue shared buffer: a directed opening over the
// value extremes, empty queues and a reused queue, then fill, drain and mixed
// phases of random requests that run the shared store into full and the
// queues into empty. Both channels idle at random; the checker predicts and
// compares, this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;

   localparam int IDLE_LIMIT = 2000;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic               req_operation = mqsb_pkg::OP_ENQ;
   logic [2:0]         req_queue_id  = 3'd0;
   logic signed [31:0] req_data_in   = 32'sd0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic signed [31:0] rsp_data_out;
   logic [1:0]         rsp_status;

   int  fail_count;
   int  pending;
   int  idle_cycles = 0;
   bit  req_burst   = 1'b0;

   multi_queue_shared_buffer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_queue_id  (req_queue_id),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status)
   );

   mqsb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_queue_id  (req_queue_id),
      .req_data_in   (req_data_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // one request beat, after a random gap or none in a burst stretch
   task automatic issue_request(input logic op, input logic [2:0] qid,
                                input logic signed [31:0] din);
      int gap;
      if ($urandom_range(0, 39) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_queue_id  <= qid;
      req_data_in   <= din;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // result side: random hold-off before each beat, stretches without one
   initial begin : rsp_side
      int gap;
      bit burst;
      burst = 1'b0;
      forever begin
         if ($urandom_range(0, 39) == 0)
            burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                 n;
      int                 enq_pct;
      logic               op;
      logic [2:0]         qid;
      logic signed [31:0] din;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queues, value extremes, drain past empty, reuse
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd7, 32'sh7fffffff);
      issue_request(mqsb_pkg::OP_ENQ, 3'd0, 32'sh7fffffff);
      issue_request(mqsb_pkg::OP_ENQ, 3'd0, 32'sh80000000);
      issue_request(mqsb_pkg::OP_ENQ, 3'd7, 32'sd0);
      issue_request(mqsb_pkg::OP_ENQ, 3'd7, -32'sd1);
      issue_request(mqsb_pkg::OP_ENQ, 3'd3, 32'sh55555555);
      issue_request(mqsb_pkg::OP_ENQ, 3'd4, 32'shaaaaaaaa);
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, -32'sd1);
      issue_request(mqsb_pkg::OP_DEQ, 3'd7, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd7, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd3, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd4, 32'sd0);
      // stale tail: queue 0 refilled after it ran empty
      issue_request(mqsb_pkg::OP_ENQ, 3'd0, 32'sd12345);
      issue_request(mqsb_pkg::OP_ENQ, 3'd0, -32'sd12345);
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, 32'sd0);
      issue_request(mqsb_pkg::OP_DEQ, 3'd0, 32'sd0);

      // random: fill into store full, drain into empty queues, then mixed
      for (n = 0; n < 910; n++) begin
         if (n < 380)
            enq_pct = 92;
         else if (n < 710)
            enq_pct = 12;
         else
            enq_pct = 50;
         op  = ($urandom_range(0, 99) < enq_pct) ? mqsb_pkg::OP_ENQ : mqsb_pkg::OP_DEQ;
         qid = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 15))
            0:       din = 32'sh7fffffff;
            1:       din = 32'sh80000000;
            2:       din = 32'sd0;
            3:       din = -32'sd1;
            default: din = $urandom;
         endcase
         issue_request(op, qid, din);
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the block settle
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
